@@ rtl/clipped_sprite_blit_addressing_assert.svh @@
// Assertion macros for the checker file of the sprite blit address generator.
`ifndef CLIPPED_SPRITE_BLIT_ADDRESSING_ASSERT_SVH
`define CLIPPED_SPRITE_BLIT_ADDRESSING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSBA_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csba checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSBA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csba checker: property failed");

// Next-cycle implication that is also checked across reset.
`define CSBA_ASSERT_RESET(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("csba checker: reset property failed");

`endif

@@ rtl/csba_pkg.sv @@
// Package with the types and constants of the sprite blit address generator.
package csba_pkg;

    localparam int unsigned SCREEN_WIDTH_DEF  = 320;
    localparam int unsigned SCREEN_HEIGHT_DEF = 240;
    localparam int unsigned QUEUE_DEPTH_DEF   = 4;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 13;

    localparam logic [CFG_DATA_W-1:0] ATLAS_RESET = 13'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ATLAS_WIDTH  = 4'd0,
        REG_ATLAS_HEIGHT = 4'd1
    } t_reg_addr;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef logic signed [18:0] t_coord;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] atlas_width;
        logic [CFG_DATA_W-1:0] atlas_height;
    } t_cfg;

    typedef struct packed {
        logic        is_step;
        logic        visible;
        logic [23:0] base;
        logic [11:0] first_col;
        logic [11:0] last_col;
        logic [11:0] first_row;
        logic [11:0] last_row;
    } t_cmd;

endpackage

@@ rtl/csba_if.sv @@
// Channel interfaces of the sprite blit address generator: input, result and configuration.
interface csba_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic signed [15:0] sprite_width;
    logic signed [15:0] sprite_height;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;

    modport source (
        output valid, operation, source_x, source_y, sprite_width, sprite_height,
               target_x, target_y,
        input  ready
    );
    modport sink (
        input  valid, operation, source_x, source_y, sprite_width, sprite_height,
               target_x, target_y,
        output ready
    );
endinterface

interface csba_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] source_offset;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic        last_pixel;

    modport source (
        output valid, source_offset, screen_x, screen_y, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, source_offset, screen_x, screen_y, last_pixel,
        output ready
    );
endinterface

interface csba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csba_pkg::CFG_ADDR_W-1:0] addr;
    logic [csba_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

@@ rtl/csba_front.sv @@
// Front part: accepts input beats, clips start rectangles and builds queue commands.
module csba_front #(
    parameter int unsigned SCREEN_WIDTH  = csba_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = csba_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csba_in_if.sink         i_in,
    input  csba_pkg::t_cfg  i_cfg,
    input  logic            i_q_ready,
    output logic            o_push,
    output csba_pkg::t_cmd  o_cmd
);

    localparam csba_pkg::t_coord SW = csba_pkg::t_coord'(SCREEN_WIDTH);
    localparam csba_pkg::t_coord SH = csba_pkg::t_coord'(SCREEN_HEIGHT);

    function automatic csba_pkg::t_coord max3(csba_pkg::t_coord a, csba_pkg::t_coord b,
                                              csba_pkg::t_coord c);
        csba_pkg::t_coord r;
        r = (a > b) ? a : b;
        return (r > c) ? r : c;
    endfunction

    function automatic csba_pkg::t_coord min3(csba_pkg::t_coord a, csba_pkg::t_coord b,
                                              csba_pkg::t_coord c);
        csba_pkg::t_coord r;
        r = (a < b) ? a : b;
        return (r < c) ? r : c;
    endfunction

    logic             s1_ready;
    csba_pkg::t_coord sx, sy, wd, ht, dx, dy, aw, ah, off_x, off_y;
    csba_pkg::t_coord n_col_lo, n_col_hi, n_row_lo, n_row_hi;

    logic             r_s1_valid;
    logic             r_s1_step;
    csba_pkg::t_coord r_col_lo, r_col_hi, r_row_lo, r_row_hi, r_off_x, r_off_y;

    csba_pkg::t_coord first_c, last_c, first_r, last_r;
    logic [25:0]      prod;

    assign s1_ready   = !r_s1_valid || i_q_ready;
    assign i_in.ready = s1_ready;

    always_comb begin
        sx       = csba_pkg::t_coord'(i_in.source_x);
        sy       = csba_pkg::t_coord'(i_in.source_y);
        wd       = csba_pkg::t_coord'(i_in.sprite_width);
        ht       = csba_pkg::t_coord'(i_in.sprite_height);
        dx       = csba_pkg::t_coord'(i_in.target_x);
        dy       = csba_pkg::t_coord'(i_in.target_y);
        aw       = csba_pkg::t_coord'({1'b0, i_cfg.atlas_width});
        ah       = csba_pkg::t_coord'({1'b0, i_cfg.atlas_height});
        off_x    = sx - dx;
        off_y    = sy - dy;
        n_col_lo = max3(sx, '0, off_x);
        n_col_hi = min3(sx + wd, aw, off_x + SW);
        n_row_lo = max3(sy, '0, off_y);
        n_row_hi = min3(sy + ht, ah, off_y + SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in.valid) begin
            r_s1_step <= (i_in.operation == csba_pkg::OP_STEP);
            r_col_lo  <= n_col_lo;
            r_col_hi  <= n_col_hi;
            r_row_lo  <= n_row_lo;
            r_row_hi  <= n_row_hi;
            r_off_x   <= off_x;
            r_off_y   <= off_y;
        end
    end

    // A visible window lies inside the atlas, so its low corner fits in 13 bits.
    always_comb begin
        first_c = r_col_lo - r_off_x;
        last_c  = r_col_hi - csba_pkg::t_coord'(1) - r_off_x;
        first_r = r_row_lo - r_off_y;
        last_r  = r_row_hi - csba_pkg::t_coord'(1) - r_off_y;
        prod    = {13'b0, r_row_lo[12:0]} * {13'b0, i_cfg.atlas_width};

        o_cmd.is_step   = r_s1_step;
        o_cmd.visible   = (r_col_lo < r_col_hi) && (r_row_lo < r_row_hi);
        o_cmd.base      = prod[23:0] + {11'b0, r_col_lo[12:0]};
        o_cmd.first_col = first_c[11:0];
        o_cmd.last_col  = last_c[11:0];
        o_cmd.first_row = first_r[11:0];
        o_cmd.last_row  = last_r[11:0];
    end

    assign o_push = r_s1_valid && i_q_ready;

endmodule

@@ rtl/csba_queue.sv @@
// Command queue that decouples the front part from the back part.
module csba_queue #(
    parameter int unsigned DEPTH = csba_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csba_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output csba_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    csba_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = push_ok ? ((r_wr == LAST_PTR) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = pop_ok ? ((r_rd == LAST_PTR) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count;
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ rtl/csba_back.sv @@
// Back part: holds the clipped window, walks it and drives the result register.
module csba_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csba_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  csba_pkg::t_cmd i_cmd,
    output logic           o_pop,
    csba_out_if.source     o_out
);

    logic        r_active, n_active;
    logic [23:0] r_base, n_base;
    logic [11:0] r_first_col, n_first_col;
    logic [11:0] r_last_col, n_last_col;
    logic [11:0] r_cur_col, n_cur_col;
    logic [11:0] r_cur_row, n_cur_row;
    logic [11:0] r_last_row, n_last_row;

    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_offset, n_out_offset;
    logic [11:0] r_out_x, n_out_x;
    logic [11:0] r_out_y, n_out_y;
    logic        r_out_last, n_out_last;

    logic        end_row, end_all;
    logic [11:0] col_diff;

    assign o_pop = i_q_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        col_diff = r_cur_col - r_first_col;
        end_row  = (r_cur_col == r_last_col);
        end_all  = end_row && (r_cur_row == r_last_row);

        n_active     = r_active;
        n_base       = r_base;
        n_first_col  = r_first_col;
        n_last_col   = r_last_col;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_last_row   = r_last_row;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_offset = r_out_offset;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_last   = r_out_last;

        if (o_pop) begin
            if (!i_cmd.is_step) begin
                n_active    = i_cmd.visible;
                n_base      = i_cmd.base;
                n_first_col = i_cmd.first_col;
                n_last_col  = i_cmd.last_col;
                n_cur_col   = i_cmd.first_col;
                n_cur_row   = i_cmd.first_row;
                n_last_row  = i_cmd.last_row;
                n_out_valid = 1'b0;
            end else if (r_active) begin
                n_out_valid  = 1'b1;
                n_out_offset = r_base + {12'b0, col_diff};
                n_out_x      = r_cur_col;
                n_out_y      = r_cur_row;
                n_out_last   = end_all;
                if (end_all) begin
                    n_active = 1'b0;
                end else if (end_row) begin
                    n_cur_col = r_first_col;
                    n_cur_row = r_cur_row + 1'b1;
                    n_base    = r_base + {11'b0, i_cfg.atlas_width};
                end else begin
                    n_cur_col = r_cur_col + 1'b1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_first_col  <= n_first_col;
        r_last_col   <= n_last_col;
        r_cur_col    <= n_cur_col;
        r_cur_row    <= n_cur_row;
        r_last_row   <= n_last_row;
        r_out_offset <= n_out_offset;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.source_offset = r_out_offset;
    assign o_out.screen_x      = r_out_x;
    assign o_out.screen_y      = r_out_y;
    assign o_out.last_pixel    = r_out_last;

endmodule

@@ rtl/clipped_sprite_blit_addressing.sv @@
// Top level of the clipped sprite blit address generator.
// The block takes input beats on i_in: a start beat clips a source rectangle against the
// atlas and the screen, and each step beat yields the next visible pixel on o_out with its
// atlas offset, screen position and a mark on the final pixel.
// A start beat and a step beat with no blit pending produce no result beat.
// The user must write the atlas size through i_cfg only while the block is idle; the block
// itself does not enforce this. i_cfg is always ready.
// While the receiver does not stall, the block sustains one input beat per cycle: a front
// (clip compare, then the row times pitch multiply) feeds a command queue, and the back walks
// the window at one pixel per cycle into a single output register.
// When the receiver stalls, the result holds in the output register, the queue fills, and
// i_in.ready drops once the queue and the front stage are full.
// A synchronous reset on i_rst_n empties the front and the queue, drops any pending blit
// and sets both atlas registers to 256.
module clipped_sprite_blit_addressing #(
    parameter int unsigned SCREEN_WIDTH  = csba_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = csba_pkg::SCREEN_HEIGHT_DEF,
    parameter int unsigned QUEUE_DEPTH   = csba_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csba_cfg_if.sink    i_cfg,
    csba_in_if.sink     i_in,
    csba_out_if.source  o_out
);

    csba_pkg::t_cfg r_cfg;
    logic           q_ready, q_valid, push, pop;
    csba_pkg::t_cmd push_cmd, pop_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.atlas_width  <= csba_pkg::ATLAS_RESET;
            r_cfg.atlas_height <= csba_pkg::ATLAS_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.addr == csba_pkg::REG_ATLAS_WIDTH) begin
                r_cfg.atlas_width <= i_cfg.data;
            end
            if (i_cfg.addr == csba_pkg::REG_ATLAS_HEIGHT) begin
                r_cfg.atlas_height <= i_cfg.data;
            end
        end
    end

    csba_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    csba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (pop_cmd),
        .i_pop   (pop)
    );

    csba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_cmd     (pop_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ rtl/csba_checker.sv @@
// Port checker of the sprite blit address generator and its bind to the top level.
`include "clipped_sprite_blit_addressing_assert.svh"

module csba_checker #(
    parameter int unsigned SCREEN_WIDTH  = csba_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = csba_pkg::SCREEN_HEIGHT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [23:0] i_out_offset,
    input logic [11:0] i_out_x,
    input logic [11:0] i_out_y,
    input logic        i_out_last
);

    localparam logic [12:0] X_LIMIT = 13'(SCREEN_WIDTH);
    localparam logic [12:0] Y_LIMIT = 13'(SCREEN_HEIGHT);

    `CSBA_ASSERT_RESET(a_reset_clears_out, !i_rst_n, !i_out_valid)

    `CSBA_ASSERT_NEXT(a_stall_keeps_valid, i_out_valid && !i_out_ready, i_out_valid)

    `CSBA_ASSERT_NEXT(a_stall_keeps_beat, i_out_valid && !i_out_ready, $stable(i_out_offset) && $stable(i_out_x) && $stable(i_out_y) && $stable(i_out_last))

    `CSBA_ASSERT_IMPL(a_x_on_screen, i_out_valid, {1'b0, i_out_x} < X_LIMIT)

    `CSBA_ASSERT_IMPL(a_y_on_screen, i_out_valid, {1'b0, i_out_y} < Y_LIMIT)

endmodule

bind clipped_sprite_blit_addressing csba_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_csba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_offset (o_out.source_offset),
    .i_out_x      (o_out.screen_x),
    .i_out_y      (o_out.screen_y),
    .i_out_last   (o_out.last_pixel)
);
